FILE: rtl/elcsr_pkg.sv
// elcsr_pkg: request codes, status codes and field widths of the graph store.
// No dependencies.
`default_nettype none
package elcsr_pkg;
   localparam int VertexWidth = 10;
   localparam int CountWidth  = 13;
   localparam int BoundWidth  = 11;

   typedef enum logic [1:0] {
      REQ_ADD      = 2'd0,
      REQ_FINALIZE = 2'd1,
      REQ_QUERY    = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_type_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SELF  = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [VertexWidth-1:0] vertex_a;
      logic [VertexWidth-1:0] vertex_b;
   } req_type_payload_type;

   typedef struct packed {
      logic [1:0]            status;
      logic                  found;
      logic [CountWidth-1:0] edge_count;
      logic [CountWidth-1:0] degree_a;
   } rsp_payload_type;
endpackage
`default_nettype wire

FILE: rtl/elcsr_if.sv
// elcsr_if: valid/ready channel carrying a payload of type T.
// Depends on nothing; payload types come from elcsr_pkg.
`default_nettype none
interface elcsr_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/edge_list_to_csr_graph_store.sv
// edge_list_to_csr_graph_store: undirected graph store with compressed adjacency.
// Depends on elcsr_pkg and elcsr_if.
//
//  channel | dir | beat
//  req     | in  | req_type, vertex_a, vertex_b
//  rsp     | out | status, found, edge_count, degree_a
//  csr     | in  | num_vertices (11 bit)
//
// A query looks through the adjacency or through the edge list; a clear ends
// with a zeroing sweep of the degree memory. After reset the same sweep zeroes
// the degree memory; req is held off meanwhile. A new request is taken once
// the previous beat has gone; the response register holds its beat while
// rsp_ready is low.
`default_nettype none
module edge_list_to_csr_graph_store #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
) (
   input  wire logic clock,
   input  wire logic reset,
   elcsr_if.sink     req,
   elcsr_if.source   rsp,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [elcsr_pkg::BoundWidth-1:0] csr_data
);
   import elcsr_pkg::*;

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NW = $clog2(2 * MAX_EDGES);
   localparam int TW = $clog2(MAX_EDGES + 1);     // edge total
   localparam int RW = $clog2(2 * MAX_EDGES + 1); // row start / degree
   localparam int AW = (VW > VertexWidth) ? VW : VertexWidth;

   // memories
   logic [2*VertexWidth-1:0] edge_mem [MAX_EDGES];
   logic [RW-1:0] deg_mem  [MAX_VERTICES];
   logic [RW-1:0] row_mem  [MAX_VERTICES];  // row start of each vertex
   logic [RW-1:0] fill_mem [MAX_VERTICES];
   logic [VertexWidth-1:0] nbr_mem [2*MAX_EDGES];

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_ADD_RD, S_ADD_A, S_ADD_B, S_ADD_B2,
      S_Q_RD, S_Q_ROW, S_Q_SCAN, S_Q_EDGE, S_Q_EDGE2,
      S_F_PFX, S_F_PFX2, S_F_E_RD, S_F_U, S_F_U2, S_F_V, S_F_V2,
      S_DEG_RD, S_DEG_RD2, S_RSP
   } state_type;

   state_type state_ff;
   logic [BoundWidth-1:0] nv_ff;
   logic [TW-1:0] total_ff;
   logic cur_ff;
   logic [1:0] type_ff;
   logic [VertexWidth-1:0] a_ff, b_ff;
   logic [VW:0] vi_ff;          // vertex sweep index
   logic [TW-1:0] ei_ff;        // edge / scan index
   logic [RW-1:0] acc_ff, row_ff, deg_ff;
   logic [VertexWidth-1:0] eu_ff, ev_ff;
   logic [1:0] st_ff;
   logic found_ff;
   rsp_payload_type rsp_ff;
   logic rsp_v_ff;

   // registered read data
   logic [RW-1:0] deg_q, row_q, fill_q;
   logic [2*VertexWidth-1:0] edge_q;
   logic [VertexWidth-1:0] nbr_q;

   // memory control (combinational)
   logic deg_we, row_we, fill_we, nbr_we, edge_we;
   logic [VW-1:0] deg_addr, row_addr, fill_addr;
   logic [RW-1:0] deg_wd, row_wd, fill_wd;
   logic [EW-1:0] edge_addr;
   logic [NW-1:0] nbr_addr;

   logic [BoundWidth-1:0] bound;
   logic a_ok, b_ok;
   assign bound = (32'(nv_ff) < MAX_VERTICES) ? nv_ff : BoundWidth'(MAX_VERTICES);
   assign a_ok  = {1'b0, a_ff} < bound;
   assign b_ok  = {1'b0, b_ff} < bound;

   assign csr_ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp.valid = rsp_v_ff;
   assign rsp.data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (deg_we)  deg_mem[deg_addr]   <= deg_wd;
      deg_q <= deg_mem[deg_addr];
      if (row_we)  row_mem[row_addr]   <= row_wd;
      row_q <= row_mem[row_addr];
      if (fill_we) fill_mem[fill_addr] <= fill_wd;
      fill_q <= fill_mem[fill_addr];
      if (edge_we) edge_mem[edge_addr] <= {a_ff, b_ff};
      edge_q <= edge_mem[edge_addr];
      if (nbr_we)  nbr_mem[nbr_addr]   <= (state_ff == S_F_U2) ? ev_ff : eu_ff;
      nbr_q <= nbr_mem[nbr_addr];
   end

   always_comb begin
      deg_we = 1'b0; row_we = 1'b0; fill_we = 1'b0; nbr_we = 1'b0; edge_we = 1'b0;
      deg_addr = VW'(a_ff); row_addr = VW'(a_ff); fill_addr = VW'(a_ff);
      deg_wd = '0; row_wd = acc_ff; fill_wd = '0;
      edge_addr = EW'(ei_ff);
      nbr_addr = NW'(row_ff + RW'(ei_ff));
      unique case (state_ff)
         S_INIT: begin
            deg_we = 1'b1; deg_addr = vi_ff[VW-1:0];
         end
         S_IDLE: begin
            deg_addr = VW'(req.data.vertex_a); row_addr = VW'(req.data.vertex_a);
         end
         S_ADD_RD: deg_addr = VW'(a_ff);
         S_ADD_A: begin
            deg_we = 1'b1; deg_wd = deg_q + 1'b1;
            edge_we = 1'b1; edge_addr = EW'(total_ff);
         end
         S_ADD_B: deg_addr = VW'(b_ff);
         S_ADD_B2: begin
            deg_addr = VW'(b_ff); deg_we = 1'b1; deg_wd = deg_q + 1'b1;
         end
         S_F_PFX: begin
            deg_addr = vi_ff[VW-1:0];
         end
         S_F_PFX2: begin
            row_we = 1'b1; row_addr = vi_ff[VW-1:0]; row_wd = acc_ff;
            fill_we = 1'b1; fill_addr = vi_ff[VW-1:0]; fill_wd = acc_ff;
         end
         S_F_E_RD: edge_addr = EW'(ei_ff);
         // edge word has arrived in edge_q; eu_ff is only loaded from it as this state ends
         S_F_U: fill_addr = VW'(edge_q[2*VertexWidth-1:VertexWidth]);
         S_F_U2: begin
            fill_addr = VW'(eu_ff); fill_we = 1'b1; fill_wd = fill_q + 1'b1;
            nbr_we = 1'b1; nbr_addr = NW'(fill_q);
         end
         S_F_V: fill_addr = VW'(ev_ff);
         S_F_V2: begin
            fill_addr = VW'(ev_ff); fill_we = 1'b1; fill_wd = fill_q + 1'b1;
            nbr_we = 1'b1; nbr_addr = NW'(fill_q);
         end
         S_Q_SCAN: nbr_addr = NW'(row_ff + RW'(ei_ff));
         S_Q_EDGE: edge_addr = EW'(ei_ff);
         S_DEG_RD: deg_addr = VW'(a_ff);
         default: ;
      endcase
   end

   function automatic rsp_payload_type mk_rsp(input logic [1:0] st, input logic f,
                                            input logic [TW-1:0] t, input logic [RW-1:0] d,
                                            input logic valid_a);
      rsp_payload_type r;
      r.status = st; r.found = f;
      r.edge_count = CountWidth'(t);
      r.degree_a = valid_a ? CountWidth'(d) : '0;
      return r;
   endfunction

   logic a_in_mem;
   assign a_in_mem = {{(AW-VertexWidth+1){1'b0}}, a_ff} < (AW+1)'(MAX_VERTICES);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; vi_ff <= '0; nv_ff <= BoundWidth'(1024);
         total_ff <= '0; cur_ff <= 1'b0; rsp_v_ff <= 1'b0; type_ff <= REQ_ADD;
      end else begin
         if (csr_valid) nv_ff <= csr_data;
         if (rsp_v_ff && rsp.ready) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            S_INIT: begin
               vi_ff <= vi_ff + 1'b1;
               if (vi_ff == (VW+1)'(MAX_VERTICES - 1)) begin
                  state_ff <= S_IDLE;
                  // clear finishes its sweep: report with degree zero
                  if (type_ff == REQ_CLEAR) begin
                     rsp_ff <= mk_rsp(ST_OK, 1'b0, '0, '0, 1'b0);
                     rsp_v_ff <= 1'b1;
                  end
               end
            end
            S_IDLE: if (req.valid && !rsp_v_ff) begin
               type_ff <= req.data.req_type; a_ff <= req.data.vertex_a;
               b_ff <= req.data.vertex_b; st_ff <= ST_OK; found_ff <= 1'b0;
               acc_ff <= '0; vi_ff <= '0; ei_ff <= '0;
               unique case (req_type_type'(req.data.req_type))
                  REQ_ADD:      state_ff <= S_ADD_RD;
                  REQ_FINALIZE: state_ff <= S_F_PFX;
                  REQ_QUERY:    state_ff <= S_Q_RD;
                  REQ_CLEAR: begin
                     total_ff <= '0; cur_ff <= 1'b0; state_ff <= S_INIT;
                  end
               endcase
            end
            S_ADD_RD: begin
               priority if (a_ff == b_ff) begin
                  st_ff <= ST_SELF; state_ff <= S_DEG_RD;
               end else if (!a_ok || !b_ok) begin
                  st_ff <= ST_RANGE; state_ff <= S_DEG_RD;
               end else if (total_ff >= TW'(MAX_EDGES)) begin
                  st_ff <= ST_FULL; state_ff <= S_DEG_RD;
               end else state_ff <= S_ADD_A;
            end
            S_ADD_A: begin
               total_ff <= total_ff + 1'b1; cur_ff <= 1'b0; found_ff <= 1'b1;
               state_ff <= S_ADD_B;
            end
            S_ADD_B: state_ff <= S_ADD_B2;
            S_ADD_B2: state_ff <= S_DEG_RD;
            S_Q_RD: begin
               priority if (!a_ok || !b_ok) begin
                  st_ff <= ST_RANGE; state_ff <= S_DEG_RD;
               end else if (a_ff == b_ff) state_ff <= S_DEG_RD;
               else if (cur_ff) state_ff <= S_Q_ROW;
               else state_ff <= S_Q_EDGE;
            end
            S_Q_ROW: begin
               // deg_q and row_q hold vertex_a, read again while in S_Q_RD
               deg_ff <= deg_q; row_ff <= row_q; ei_ff <= '0;
               state_ff <= (deg_q == '0) ? S_DEG_RD : S_Q_SCAN;
            end
            S_Q_SCAN: begin
               // address ei issued now, data compared next cycle
               if (ei_ff != '0 && nbr_q == b_ff) begin
                  found_ff <= 1'b1; state_ff <= S_DEG_RD;
               end else if (RW'(ei_ff) == deg_ff) state_ff <= S_DEG_RD;
               else ei_ff <= ei_ff + 1'b1;
            end
            S_Q_EDGE: begin
               if (ei_ff != '0 && ((edge_q == {a_ff, b_ff}) || (edge_q == {b_ff, a_ff}))) begin
                  found_ff <= 1'b1; state_ff <= S_DEG_RD;
               end else if (ei_ff == total_ff) state_ff <= S_DEG_RD;
               else ei_ff <= ei_ff + 1'b1;
            end
            S_F_PFX: state_ff <= S_F_PFX2;
            S_F_PFX2: begin
               acc_ff <= acc_ff + deg_q;
               vi_ff <= vi_ff + 1'b1;
               if (vi_ff == (VW+1)'(MAX_VERTICES - 1)) begin
                  ei_ff <= '0;
                  state_ff <= (total_ff == '0) ? S_DEG_RD : S_F_E_RD;
               end else state_ff <= S_F_PFX;
            end
            S_F_E_RD: state_ff <= S_F_U;
            S_F_U: begin
               eu_ff <= edge_q[2*VertexWidth-1:VertexWidth];
               ev_ff <= edge_q[VertexWidth-1:0];
               state_ff <= S_F_U2;
            end
            S_F_U2: state_ff <= S_F_V;
            S_F_V: state_ff <= S_F_V2;
            S_F_V2: begin
               ei_ff <= ei_ff + 1'b1;
               if (ei_ff + 1'b1 == total_ff) begin
                  cur_ff <= 1'b1; state_ff <= S_DEG_RD;
               end else state_ff <= S_F_E_RD;
            end
            S_DEG_RD: begin
               if (type_ff == REQ_FINALIZE) cur_ff <= 1'b1;
               state_ff <= S_DEG_RD2;
            end
            S_DEG_RD2: begin
               rsp_ff <= mk_rsp(st_ff, found_ff, total_ff, deg_q, a_in_mem);
               rsp_v_ff <= 1'b1; state_ff <= S_IDLE;
            end
            S_RSP: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/elcsr_checker.sv
// elcsr_checker: port-level checks on the graph store, bound to the top level.
// Depends on elcsr_pkg; binds into edge_list_to_csr_graph_store.
`default_nettype none
module elcsr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic rsp_found
);
   import elcsr_pkg::*;
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req taken with rsp pending");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK) else $error("found with error");
endmodule

bind edge_list_to_csr_graph_store elcsr_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
   .rsp_found(rsp.data.found));
`default_nettype wire

FILE: sim/tb_edge_list_to_csr_graph_store.sv
// tb_edge_list_to_csr_graph_store: self-checking bench for the graph store.
// Depends on elcsr_pkg, elcsr_if and edge_list_to_csr_graph_store.
// A shadow graph predicts every response beat; directed tests, then random traffic.
`default_nettype none
module tb_edge_list_to_csr_graph_store;
   import elcsr_pkg::*;

   localparam int MaxVertices = 1024;
   localparam int MaxEdges    = 4096;

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [BoundWidth-1:0] csr_data;

   elcsr_if #(.T(req_type_payload_type)) req_if ();
   elcsr_if #(.T(rsp_payload_type))      rsp_if ();

   edge_list_to_csr_graph_store #(
      .MAX_VERTICES(MaxVertices),
      .MAX_EDGES   (MaxEdges)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .rsp      (rsp_if),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   // shadow graph: the edge list and the degrees are all a response needs,
   // since a current adjacency always mirrors the edge list it was built from
   logic [VertexWidth-1:0] shadow_u [MaxEdges];
   logic [VertexWidth-1:0] shadow_v [MaxEdges];
   logic [CountWidth-1:0]  shadow_degree [MaxVertices];
   int unsigned            shadow_edges;
   int unsigned            vertex_limit;   // min(num_vertices, MaxVertices)

   rsp_payload_type pending_rsp [$];       // expected response beats, oldest first
   int unsigned     error_count;
   int unsigned     sender_idle_pct;
   int unsigned     receiver_stall_pct;
   int unsigned     hold_left;             // long back-pressure stretch, in cycles

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // a separate watchdog; the slowest run is far below this
   initial begin
      #(12 * 4000000);
      $display("tb_edge_list_to_csr_graph_store: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // apply one request to the shadow graph and return the beat it must give
   function automatic rsp_payload_type graph_apply(input req_type_type kind,
                                                   input logic [VertexWidth-1:0] a,
                                                   input logic [VertexWidth-1:0] b);
      rsp_payload_type r;
      r = '0;
      r.status = ST_OK;
      case (kind)
         REQ_ADD: begin
            if (a == b) r.status = ST_SELF;
            else if (a >= vertex_limit || b >= vertex_limit) r.status = ST_RANGE;
            else if (shadow_edges >= MaxEdges) r.status = ST_FULL;
            else begin
               shadow_u[shadow_edges] = a;
               shadow_v[shadow_edges] = b;
               shadow_edges++;
               shadow_degree[a]++;
               shadow_degree[b]++;
               r.found = 1'b1;
            end
         end
         REQ_QUERY: begin
            if (a >= vertex_limit || b >= vertex_limit) r.status = ST_RANGE;
            else if (a != b) begin
               for (int i = 0; i < shadow_edges; i++) begin
                  if ((shadow_u[i] == a && shadow_v[i] == b) ||
                      (shadow_u[i] == b && shadow_v[i] == a)) begin
                     r.found = 1'b1;
                     break;
                  end
               end
            end
         end
         REQ_CLEAR: begin
            shadow_edges = 0;
            for (int i = 0; i < MaxVertices; i++) shadow_degree[i] = '0;
         end
         default: ;   // finalize leaves the counts alone
      endcase
      r.edge_count = shadow_edges[CountWidth-1:0];
      r.degree_a   = shadow_degree[a];
      return r;
   endfunction

   // receiver: checks each response beat, then decides ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) report_mismatch("response with nothing expected");
         else begin
            rsp_payload_type want;
            want = pending_rsp.pop_front();
            if (rsp_if.data.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_if.data.status, want.status));
            if (rsp_if.data.found !== want.found)
               report_mismatch($sformatf("found %0b, expected %0b",
                                         rsp_if.data.found, want.found));
            if (rsp_if.data.edge_count !== want.edge_count)
               report_mismatch($sformatf("edge_count %0d, expected %0d",
                                         rsp_if.data.edge_count, want.edge_count));
            if (rsp_if.data.degree_a !== want.degree_a)
               report_mismatch($sformatf("degree_a %0d, expected %0d",
                                         rsp_if.data.degree_a, want.degree_a));
         end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
   end

   // the long hold counts down in a process of its own
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // one request beat; idle gaps first, then hold valid until ready is seen
   task automatic send_req(input req_type_type kind,
                           input logic [VertexWidth-1:0] a,
                           input logic [VertexWidth-1:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= '{req_type: kind, vertex_a: a, vertex_b: b};
      do @(posedge clock); while (!req_if.ready);
      pending_rsp.push_back(graph_apply(kind, a, b));
   endtask

   task automatic drain_responses();
      req_if.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      @(posedge clock);
   endtask

   // num_vertices only changes with the store idle
   task automatic write_vertex_count(input int unsigned count);
      drain_responses();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= count[BoundWidth-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      vertex_limit = (count < MaxVertices) ? count : MaxVertices;
   endtask

   task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // adds, lookups through the edge list and through fresh adjacency, staleness, clear
   task automatic test_basic_ops();
      send_req(REQ_ADD, 10'd0, 10'd1023);
      send_req(REQ_ADD, 10'd1023, 10'd0);      // duplicate edges are kept
      send_req(REQ_ADD, 10'd7, 10'd7);         // self loop
      send_req(REQ_ADD, 10'd512, 10'd341);
      send_req(REQ_QUERY, 10'd1023, 10'd0);
      send_req(REQ_QUERY, 10'd3, 10'd0);
      send_req(REQ_QUERY, 10'd7, 10'd7);       // self query: ok, never found
      send_req(REQ_FINALIZE, 10'd0, 10'd0);
      send_req(REQ_QUERY, 10'd341, 10'd512);
      send_req(REQ_QUERY, 10'd0, 10'd512);
      send_req(REQ_ADD, 10'd682, 10'd5);       // adjacency goes stale
      send_req(REQ_QUERY, 10'd5, 10'd682);
      send_req(REQ_CLEAR, 10'd1023, 10'd0);
      send_req(REQ_QUERY, 10'd0, 10'd1023);
      send_req(REQ_FINALIZE, 10'd512, 10'd0);  // finalize of an empty graph
      send_req(REQ_QUERY, 10'd512, 10'd341);
   endtask

   // range checks at several bounds, the zero and oversized counts among them
   task automatic test_vertex_bound();
      write_vertex_count(5);
      send_req(REQ_ADD, 10'd4, 10'd5);
      send_req(REQ_ADD, 10'd5, 10'd4);
      send_req(REQ_ADD, 10'd5, 10'd5);         // self loop wins over range
      send_req(REQ_ADD, 10'd4, 10'd3);
      send_req(REQ_QUERY, 10'd9, 10'd1);
      send_req(REQ_QUERY, 10'd3, 10'd4);
      write_vertex_count(0);
      send_req(REQ_ADD, 10'd0, 10'd1);
      send_req(REQ_QUERY, 10'd0, 10'd1);
      write_vertex_count(1);
      send_req(REQ_ADD, 10'd0, 10'd1);
      send_req(REQ_QUERY, 10'd0, 10'd0);
      write_vertex_count(2047);
      send_req(REQ_ADD, 10'd1023, 10'd1022);
      send_req(REQ_QUERY, 10'd1022, 10'd1023);
      send_req(REQ_CLEAR, 10'd4, 10'd0);
   endtask

   // fill the table with one repeated edge: top counts, then a full rejection
   task automatic test_full_table();
      write_vertex_count(1024);
      set_idling(0, 0);
      for (int i = 0; i < MaxEdges; i++) send_req(REQ_ADD, 10'd0, 10'd1);
      send_req(REQ_ADD, 10'd2, 10'd3);         // table full
      send_req(REQ_ADD, 10'd9, 10'd9);         // self loop still reported first
      send_req(REQ_QUERY, 10'd1, 10'd0);
      send_req(REQ_QUERY, 10'd2, 10'd3);
      send_req(REQ_FINALIZE, 10'd1, 10'd0);
      send_req(REQ_QUERY, 10'd0, 10'd1);
      send_req(REQ_QUERY, 10'd3, 10'd2);
      send_req(REQ_CLEAR, 10'd0, 10'd0);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      set_idling(0, 0);
      drain_responses();
      hold_left <= 400;
      for (int i = 0; i < 30; i++)
         send_req(req_type_type'($urandom_range(2)), 10'($urandom_range(7)),
                  10'($urandom_range(7)));
      send_req(REQ_CLEAR, 10'd0, 10'd0);
   endtask

   function automatic logic [VertexWidth-1:0] pick_vertex();
      if ($urandom_range(3) == 0) return VertexWidth'($urandom);
      return VertexWidth'($urandom_range(vertex_limit + 1));
   endfunction

   // mostly adds and lookups, some vertices out of range; rare clears keep scans short
   task automatic test_random_traffic(input int unsigned items);
      int unsigned roll;
      req_type_type kind;
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(99);
         if (roll < 46) kind = REQ_ADD;
         else if (roll < 90) kind = REQ_QUERY;
         else if (roll < 96) kind = REQ_FINALIZE;
         else kind = REQ_CLEAR;
         send_req(kind, pick_vertex(), pick_vertex());
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      hold_left    = 0;
      error_count  = 0;
      shadow_edges = 0;
      vertex_limit = MaxVertices;
      for (int i = 0; i < MaxVertices; i++) shadow_degree[i] = '0;
      set_idling(0, 0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_vertex_bound();
      test_full_table();
      test_backpressure();

      // random phases, each at its own vertex count and idling mix
      write_vertex_count(16);
      set_idling(0, 0);
      test_random_traffic(475);
      write_vertex_count(6);
      set_idling(68, 0);
      test_random_traffic(475);
      write_vertex_count(40);
      set_idling(0, 68);
      test_random_traffic(475);
      write_vertex_count(2047);
      set_idling(17, 17);
      test_random_traffic(475);

      drain_responses();
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("tb_edge_list_to_csr_graph_store: PASS");
      end else begin
         $display("tb_edge_list_to_csr_graph_store: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
